// ===== sv/ctk_pkg.sv =====
package ctk_pkg;

  // slot count default and field widths
  localparam int NUM_SLOTS_DEF = 8;
  localparam int SLOT_W        = 3;
  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 16;
  localparam int POS_W         = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // signed working width for position arithmetic
  localparam int CALC_W        = COUNT_W + 1;

  // gun scaling: numerator is (h_count - offset) * scale
  localparam int GUN_SCALE     = 1000;
  localparam int SCALE_W       = 10;
  localparam int NUM_W         = COUNT_W + SCALE_W;
  localparam logic [COUNT_W-1:0] GUN_H_OFFSET = COUNT_W'(140);
  localparam logic [COUNT_W-1:0] GUN_V_OFFSET = COUNT_W'(16);

  // status and type codes
  localparam logic [BYTE_W-1:0] STATUS_BAD = 8'hff;
  localparam logic [BYTE_W-1:0] TYPE_MOUSE = 8'h12;
  localparam logic [BYTE_W-1:0] TYPE_GUN   = 8'h31;

  // active-low direction bits of the first button byte
  localparam int BTN_LEFT  = 7;
  localparam int BTN_DOWN  = 6;
  localparam int BTN_RIGHT = 5;
  localparam int BTN_UP    = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GUN_DIV  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 2'd2;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] GUN_DIV_RST = 16'd5000;
  localparam logic [POS_W-1:0]      WIDTH_RST   = 10'd320;
  localparam logic [POS_W-1:0]      HEIGHT_RST  = 10'd240;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } pos_t;

  // clamp a signed value into [0, hi]
  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [CALC_W-1:0] v,
                                                 input logic [POS_W-1:0] hi);
    logic [POS_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({{(CALC_W-POS_W){1'b0}}, hi})) begin
      res = hi;
    end else begin
      res = v[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/ctk_pos_mem.sv =====
module ctk_pos_mem #(
  parameter int NUM_SLOTS = ctk_pkg::NUM_SLOTS_DEF,
  localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output ctk_pkg::pos_t      rd_data_o,
  input  logic               wr_en_i,
  input  logic [IDX_W-1:0]   wr_addr_i,
  input  ctk_pkg::pos_t      wr_data_i
);

  ctk_pkg::pos_t         mem_q [NUM_SLOTS];
  ctk_pkg::pos_t         rd_data_q;
  logic                  rd_valid_q;
  logic [NUM_SLOTS-1:0]  valid_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry valid bits, unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== sv/ctk_divider.sv =====
module ctk_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [ctk_pkg::NUM_W-1:0]          num_i,
  input  logic [ctk_pkg::CFG_DATA_W-1:0]     den_i,
  output logic                               done_o,
  output logic [ctk_pkg::NUM_W-1:0]          quot_o
);

  localparam int QW   = ctk_pkg::NUM_W;
  localparam int DW   = ctk_pkg::CFG_DATA_W;
  localparam int CNT_W = $clog2(QW);

  logic [QW-1:0]    acc_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             take;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_q, acc_q[QW-1]};
    diff  = trial - {1'b0, den_q};
    take  = (trial >= {1'b0, den_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(QW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath, quotient bits shift into the numerator register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[QW-2:0], take};
      rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// ===== sv/controller_cursor_tracker.sv =====
// controller cursor tracker
// Takes one controller report per input transfer and keeps one cursor per
// slot in a small position memory. Each report reads the slot's position
// and, for a valid slot and good status, updates it by type (mouse deltas,
// light gun capture, or pad directions), clamps it to the screen limits
// and writes it back. A result carries the effective type and position.
// Configuration writes (divisor, width, height) use their own channel and
// are always ready; write them only while the block is idle.
// A report is held in ST_READ for the memory read and in ST_WRITE for
// the update; the result register is loaded on leaving ST_WRITE, and the
// next report is taken once the sequencer is back in ST_IDLE. A light gun
// report with a valid slot, good status, a positive offset and a nonzero
// divisor runs the bit-serial divider in ST_DIV, one quotient bit per cycle
// over 26 bits. One report is in flight at a time.
// A result waits in the output register while the receiver stalls; the
// update and write-back wait until that register is free.
// Reset clears all positions to zero and loads the register defaults
// (divisor 5000, width 320, height 240).
module controller_cursor_tracker #(
  parameter int NUM_SLOTS = ctk_pkg::NUM_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // report channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ctk_pkg::SLOT_W-1:0]        slot_i,
  input  logic [ctk_pkg::BYTE_W-1:0]        status_byte_i,
  input  logic [ctk_pkg::BYTE_W-1:0]        type_byte_i,
  input  logic [ctk_pkg::BYTE_W-1:0]        button_bits_i,
  input  logic [ctk_pkg::BYTE_W-1:0]        mouse_dx_i,
  input  logic [ctk_pkg::BYTE_W-1:0]        mouse_dy_i,
  input  logic [ctk_pkg::COUNT_W-1:0]       gun_h_count_i,
  input  logic [ctk_pkg::COUNT_W-1:0]       gun_v_count_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ctk_pkg::BYTE_W-1:0]        effective_type_o,
  output logic [ctk_pkg::POS_W-1:0]         cursor_x_o,
  output logic [ctk_pkg::POS_W-1:0]         cursor_y_o,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctk_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ctk_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SW     = ctk_pkg::SLOT_W;
  localparam int BW     = ctk_pkg::BYTE_W;
  localparam int CW     = ctk_pkg::COUNT_W;
  localparam int PW     = ctk_pkg::POS_W;
  localparam int KW     = ctk_pkg::CALC_W;
  localparam int NW     = ctk_pkg::NUM_W;
  localparam int DW     = ctk_pkg::CFG_DATA_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WRITE
  } state_e;

  state_e           state_q;
  logic             out_valid_q;
  logic [BW-1:0]    out_type_q;
  logic [PW-1:0]    out_x_q;
  logic [PW-1:0]    out_y_q;

  logic [DW-1:0]    gun_div_q;
  logic [PW-1:0]    width_q;
  logic [PW-1:0]    height_q;

  logic [SW-1:0]    slot_q;
  logic [BW-1:0]    status_q;
  logic [BW-1:0]    type_q;
  logic [BW-1:0]    buttons_q;
  logic [BW-1:0]    dx_q;
  logic [BW-1:0]    dy_q;
  logic [CW-1:0]    hc_q;
  logic [CW-1:0]    vc_q;

  logic                  in_xfer;
  logic [IDX_W+SW-1:0]   slot_ext_in;
  logic [IDX_W+SW-1:0]   slot_ext_q;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  ctk_pkg::pos_t         cur_pos;
  ctk_pkg::pos_t         new_pos;
  logic                  wr_en;

  logic             slot_ok;
  logic             status_bad;
  logic             is_mouse;
  logic             is_gun;
  logic             gun_pos;
  logic             div_start;
  logic             div_done;
  logic [NW-1:0]    div_num;
  logic [NW-1:0]    quot;
  logic [CW-1:0]    h_diff;
  logic             out_free;

  logic [BW-1:0]            pressed;
  logic signed [KW-1:0]     cur_x_s;
  logic signed [KW-1:0]     cur_y_s;
  logic signed [KW-1:0]     mov_x;
  logic signed [KW-1:0]     mov_y;
  logic signed [KW-1:0]     gun_y;
  logic [PW-1:0]            gun_x;
  logic [PW-1:0]            upd_x;
  logic [PW-1:0]            upd_y;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // slot to memory address
  assign slot_ext_in = {{IDX_W{1'b0}}, slot_i};
  assign slot_ext_q  = {{IDX_W{1'b0}}, slot_q};
  assign rd_addr     = slot_ext_in[IDX_W-1:0];
  assign wr_addr     = slot_ext_q[IDX_W-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gun_div_q <= ctk_pkg::GUN_DIV_RST;
      width_q   <= ctk_pkg::WIDTH_RST;
      height_q  <= ctk_pkg::HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ctk_pkg::CFG_GUN_DIV: gun_div_q <= cfg_data_i;
        ctk_pkg::CFG_WIDTH:   width_q   <= cfg_data_i[PW-1:0];
        ctk_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // report capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      slot_q    <= slot_i;
      status_q  <= status_byte_i;
      type_q    <= type_byte_i;
      buttons_q <= button_bits_i;
      dx_q      <= mouse_dx_i;
      dy_q      <= mouse_dy_i;
      hc_q      <= gun_h_count_i;
      vc_q      <= gun_v_count_i;
    end
  end

  // report decode
  assign slot_ok    = (32'(slot_q) < 32'(NUM_SLOTS));
  assign status_bad = (status_q == ctk_pkg::STATUS_BAD);
  assign is_mouse   = (type_q == ctk_pkg::TYPE_MOUSE);
  assign is_gun     = (type_q == ctk_pkg::TYPE_GUN);
  assign gun_pos    = (hc_q > ctk_pkg::GUN_H_OFFSET);
  assign h_diff     = hc_q - ctk_pkg::GUN_H_OFFSET;
  assign div_num    = NW'(h_diff) * NW'(ctk_pkg::GUN_SCALE);
  assign div_start  = (state_q == ST_READ) && slot_ok && !status_bad && is_gun &&
                      gun_pos && (gun_div_q != '0);

  ctk_pos_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_pos_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (rd_addr),
    .rd_data_o (cur_pos),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (new_pos)
  );

  ctk_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (gun_div_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // position update for mouse and pad
  always_comb begin
    pressed = ~buttons_q;
    cur_x_s = $signed(KW'(cur_pos.x));
    cur_y_s = $signed(KW'(cur_pos.y));
    if (is_mouse) begin
      mov_x = cur_x_s + KW'($signed(dx_q));
      mov_y = cur_y_s + KW'($signed(dy_q));
    end else begin
      mov_x = cur_x_s + $signed(KW'(pressed[ctk_pkg::BTN_RIGHT]))
                      - $signed(KW'(pressed[ctk_pkg::BTN_LEFT]));
      mov_y = cur_y_s + $signed(KW'(pressed[ctk_pkg::BTN_DOWN]))
                      - $signed(KW'(pressed[ctk_pkg::BTN_UP]));
    end
  end

  // light gun position
  always_comb begin
    gun_y = $signed(KW'(vc_q)) - $signed(KW'(ctk_pkg::GUN_V_OFFSET));
    priority if (!gun_pos) begin
      gun_x = '0;
    end else if (gun_div_q == '0) begin
      gun_x = width_q;
    end else if (quot > NW'(width_q)) begin
      gun_x = width_q;
    end else begin
      gun_x = quot[PW-1:0];
    end
  end

  // clamp and write back
  always_comb begin
    if (is_gun) begin
      upd_x = gun_x;
      upd_y = ctk_pkg::clamp_pos(gun_y, height_q);
    end else begin
      upd_x = ctk_pkg::clamp_pos(mov_x, width_q);
      upd_y = ctk_pkg::clamp_pos(mov_y, height_q);
    end
    new_pos.x = upd_x;
    new_pos.y = upd_y;
  end

  assign wr_en = (state_q == ST_WRITE) && out_free && slot_ok && !status_bad;

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_type_q  <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= div_start ? ST_DIV : ST_WRITE;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            priority if (!slot_ok) begin
              out_type_q <= '0;
              out_x_q    <= '0;
              out_y_q    <= '0;
            end else if (status_bad) begin
              out_type_q <= '0;
              out_x_q    <= cur_pos.x;
              out_y_q    <= cur_pos.y;
            end else begin
              out_type_q <= type_q;
              out_x_q    <= upd_x;
              out_y_q    <= upd_y;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign effective_type_o = out_type_q;
  assign cursor_x_o       = out_x_q;
  assign cursor_y_o       = out_y_q;

endmodule
